/* rtl/aoc_pkg.sv */
// aoc_pkg: shared constants for the alpha over compositor
// register indexes, field widths, reset values and pipeline latency
// no dependencies
package aoc_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int ALPHA_EPSILON_DEF = 66;

    localparam int PIX_W        = 8;
    localparam int OPACITY_W    = 17;
    localparam int OPACITY_FRAC = 16;
    localparam logic [OPACITY_W-1:0] OPACITY_ONE = 17'h10000;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = OPACITY_W;
    localparam logic [CFG_INDEX_W-1:0] REG_LAYER_OPACITY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LAYER_VISIBLE = 2'd1;

    localparam int BYTE_MAX = 255;

    localparam int DIV255_LAT = 2;
    localparam int DIV_STEPS  = PIX_W;
    // input stage, divide by 255, three blend stages, divider steps, output stage
    localparam int PIPE_LAT   = 1 + DIV255_LAT + 3 + DIV_STEPS + 1;

endpackage

/* rtl/alpha_over_compositor_top.sv */
// alpha_over_compositor_top: source-over blend of one RGBA pixel pair per cycle
// uses aoc_pkg, aoc_div255, aoc_div_lane
//
// Takes one source and one destination pixel on every cycle that start is high
// (busy never rises) and presents the composited pixel with done for one cycle,
// at the end of the pipeline; the receiver cannot stall. The pipeline holds the
// two-stage divide by 255 for the alphas and the eight stage colour divider,
// one quotient bit per stage. Configuration writes are always ready and take
// effect on pixels started after the write.
module alpha_over_compositor_top #(
    parameter int FRAC_BITS     = aoc_pkg::FRAC_BITS_DEF,
    parameter int ALPHA_EPSILON = aoc_pkg::ALPHA_EPSILON_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [aoc_pkg::PIX_W-1:0]       src_red,
    input  logic [aoc_pkg::PIX_W-1:0]       src_green,
    input  logic [aoc_pkg::PIX_W-1:0]       src_blue,
    input  logic [aoc_pkg::PIX_W-1:0]       src_alpha,
    input  logic [aoc_pkg::PIX_W-1:0]       dst_red,
    input  logic [aoc_pkg::PIX_W-1:0]       dst_green,
    input  logic [aoc_pkg::PIX_W-1:0]       dst_blue,
    input  logic [aoc_pkg::PIX_W-1:0]       dst_alpha,
    output logic                            done,
    output logic [aoc_pkg::PIX_W-1:0]       out_red,
    output logic [aoc_pkg::PIX_W-1:0]       out_green,
    output logic [aoc_pkg::PIX_W-1:0]       out_blue,
    output logic [aoc_pkg::PIX_W-1:0]       out_alpha,
    output logic                            blended,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [aoc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [aoc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int F     = FRAC_BITS;
    localparam int PW    = aoc_pkg::PIX_W;
    localparam int OW    = aoc_pkg::OPACITY_W;
    localparam int OP_W  = F + 1;
    localparam int X_W   = F + PW + 1;
    localparam int N_W   = F + PW;
    localparam int D_W   = F + 2;
    localparam int LAT   = aoc_pkg::PIPE_LAT;
    localparam int STEPS = aoc_pkg::DIV_STEPS;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    localparam logic [F:0]     ONE_Q = {1'b1, {F{1'b0}}};
    localparam logic [F:0]     EPS_Q = (F+1)'(ALPHA_EPSILON);
    localparam logic [D_W-1:0] EPS_D = D_W'(ALPHA_EPSILON);

    typedef logic [3:0][PW-1:0] pix_t;

    typedef struct packed {
        pix_t          dst;
        logic [PW-1:0] alpha;
        logic          blend;
    } pass_t;

    // configuration
    logic [OW-1:0] opacity_reg, opacity_next;
    logic          visible_reg, visible_next;

    always_comb
    begin
        opacity_next = opacity_reg;
        visible_next = visible_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                aoc_pkg::REG_LAYER_OPACITY: opacity_next = cfg_data;
                aoc_pkg::REG_LAYER_VISIBLE: visible_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg <= aoc_pkg::OPACITY_ONE;
            visible_reg <= 1'b1;
        end
        else
        begin
            opacity_reg <= opacity_next;
            visible_reg <= visible_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    // valid bits
    logic vld_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= start && !busy;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // stage 1: opacity scale and alpha products
    logic [OW-1:0]   lo_sat;
    logic [OW+F-1:0] op_wide;
    logic [OP_W-1:0] op;
    logic [X_W-1:0]  x_sa_next, x_da_next;
    logic [X_W-1:0]  x_sa_reg, x_da_reg;
    pix_t            pix_in;
    pix_t            pix_reg [4];
    logic            vis_reg [3];

    always_comb
    begin
        lo_sat    = (opacity_reg > aoc_pkg::OPACITY_ONE) ? aoc_pkg::OPACITY_ONE : opacity_reg;
        op_wide   = {lo_sat, {F{1'b0}}};
        op        = op_wide[F+aoc_pkg::OPACITY_FRAC:aoc_pkg::OPACITY_FRAC];
        x_sa_next = {{(X_W-PW){1'b0}}, src_alpha} * {{(X_W-OP_W){1'b0}}, op};
        x_da_next = {1'b0, dst_alpha, {F{1'b0}}};
        pix_in    = {src_alpha, src_blue, src_green, src_red};
    end

    pix_t src_in, dst_in;
    assign src_in = pix_in[3:0];

    always_ff @(posedge clk)
    begin
        x_sa_reg   <= x_sa_next;
        x_da_reg   <= x_da_next;
        vis_reg[0] <= visible_reg;
        for (int i = 1; i < 3; i++)
        begin
            vis_reg[i] <= vis_reg[i-1];
        end
    end

    // destination travels beside the source
    pix_t dst_reg [4];
    assign dst_in = {dst_alpha, dst_blue, dst_green, dst_red};

    always_ff @(posedge clk)
    begin
        pix_reg[0] <= src_in;
        dst_reg[0] <= dst_in;
        for (int i = 1; i < 4; i++)
        begin
            pix_reg[i] <= pix_reg[i-1];
            dst_reg[i] <= dst_reg[i-1];
        end
    end

    // stages 2 and 3: divide by 255
    logic [X_W-8:0] sa_q, da_q;

    aoc_div255 #(.X_W(X_W)) u_div_sa (.clk(clk), .x(x_sa_reg), .q(sa_q));
    aoc_div255 #(.X_W(X_W)) u_div_da (.clk(clk), .x(x_da_reg), .q(da_q));

    // stage 4: destination weight
    logic [F:0]     sa3, da3, inv_sa;
    logic [2*F+1:0] dt_prod;
    logic [F:0]     dt_next;
    logic           blend_next;
    logic [F:0]     sa4_reg, dt4_reg;
    logic           blend4_reg;

    always_comb
    begin
        sa3        = sa_q[F:0];
        da3        = da_q[F:0];
        inv_sa     = ONE_Q - sa3;
        dt_prod    = {{(F+1){1'b0}}, da3} * {{(F+1){1'b0}}, inv_sa};
        dt_next    = dt_prod[2*F:F];
        blend_next = vis_reg[2] && (sa3 >= EPS_Q);
    end

    always_ff @(posedge clk)
    begin
        sa4_reg    <= sa3;
        dt4_reg    <= dt_next;
        blend4_reg <= blend_next;
    end

    // stage 5: colour products and output alpha
    logic [N_W-1:0] ps_next [3];
    logic [N_W-1:0] pd_next [3];
    logic [N_W-1:0] ps_reg [3];
    logic [N_W-1:0] pd_reg [3];
    logic [F:0]     oa_next, oa5_reg;
    logic           blend5_reg;
    pix_t           dst5_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ps_next[c] = {{(N_W-PW){1'b0}}, pix_reg[3][c]} * {{(N_W-F-1){1'b0}}, sa4_reg};
            pd_next[c] = {{(N_W-PW){1'b0}}, dst_reg[3][c]} * {{(N_W-F-1){1'b0}}, dt4_reg};
        end
        oa_next = sa4_reg + dt4_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            ps_reg[c] <= ps_next[c];
            pd_reg[c] <= pd_next[c];
        end
        oa5_reg    <= oa_next;
        blend5_reg <= blend4_reg;
        dst5_reg   <= dst_reg[3];
    end

    // stage 6: numerators, divisor, alpha byte
    logic [N_W-1:0] num_next [3];
    logic [N_W-1:0] num6_reg [3];
    logic [D_W-1:0] den_next, den6_reg;
    logic [F+PW:0]  oa_scaled;
    logic [PW:0]    alpha_wide;
    pass_t          pass_next;
    pass_t          pass_reg [STEPS+1];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            num_next[c] = ps_reg[c] + pd_reg[c];
        end
        den_next         = {1'b0, oa5_reg} + EPS_D;
        oa_scaled        = {oa5_reg, {PW{1'b0}}} - {{PW{1'b0}}, oa5_reg};
        alpha_wide       = oa_scaled[F+PW:F];
        pass_next.dst    = dst5_reg;
        pass_next.alpha  = alpha_wide[PW] ? {PW{1'b1}} : alpha_wide[PW-1:0];
        pass_next.blend  = blend5_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            num6_reg[c] <= num_next[c];
        end
        den6_reg    <= den_next;
        pass_reg[0] <= pass_next;
        for (int i = 1; i <= STEPS; i++)
        begin
            pass_reg[i] <= pass_reg[i-1];
        end
    end

    // stages 7 to 14: colour division
    logic [PW-1:0] quo [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        aoc_div_lane #(
            .N_W(N_W),
            .D_W(D_W),
            .Q_W(STEPS)
        ) u_lane (
            .clk(clk),
            .num(num6_reg[c]),
            .den(den6_reg),
            .quo(quo[c])
        );
    end

    // stage 15: select and register the result
    pix_t out_pix_next, out_pix_reg;
    logic blended_reg;

    always_comb
    begin
        out_pix_next = pass_reg[STEPS].dst;
        if (pass_reg[STEPS].blend)
        begin
            out_pix_next[CH_RED]   = quo[CH_RED];
            out_pix_next[CH_GREEN] = quo[CH_GREEN];
            out_pix_next[CH_BLUE]  = quo[CH_BLUE];
            out_pix_next[CH_ALPHA] = pass_reg[STEPS].alpha;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pix_reg <= out_pix_next;
        blended_reg <= pass_reg[STEPS].blend;
    end

    assign done      = vld_reg[LAT-1];
    assign out_red   = out_pix_reg[CH_RED];
    assign out_green = out_pix_reg[CH_GREEN];
    assign out_blue  = out_pix_reg[CH_BLUE];
    assign out_alpha = out_pix_reg[CH_ALPHA];
    assign blended   = blended_reg;

endmodule

/* rtl/aoc_div255.sv */
// aoc_div255: pipelined exact floor division by 255
// reciprocal multiply then one correction step; uses aoc_pkg
module aoc_div255 #(
    parameter int X_W = 25
) (
    input  logic           clk,
    input  logic [X_W-1:0] x,
    output logic [X_W-8:0] q
);

    localparam int Q_W = X_W - 7;
    localparam int P_W = X_W + Q_W;
    localparam longint unsigned RECIP_L = (64'd1 << X_W) / 64'd255;
    localparam logic [Q_W-1:0] RECIP = Q_W'(RECIP_L);
    localparam logic [X_W:0] DIV_C = (X_W+1)'(aoc_pkg::BYTE_MAX);

    logic [P_W-1:0] prod_reg;
    logic [X_W-1:0] x_reg;
    logic [Q_W-1:0] q_reg;
    logic [Q_W-1:0] q_est;
    logic [X_W:0]   q_times;
    logic [X_W:0]   rem;
    logic [Q_W-1:0] q_next;

    always_ff @(posedge clk)
    begin
        prod_reg <= {{Q_W{1'b0}}, x} * {{X_W{1'b0}}, RECIP};
        x_reg    <= x;
        q_reg    <= q_next;
    end

    // estimate is the quotient or one below it
    always_comb
    begin
        q_est   = prod_reg[P_W-1:X_W];
        q_times = {q_est, 8'd0} - {8'd0, q_est};
        rem     = {1'b0, x_reg} - q_times;
        q_next  = (rem >= DIV_C) ? q_est + Q_W'(1) : q_est;
    end

    assign q = q_reg;

endmodule

/* rtl/aoc_div_lane.sv */
// aoc_div_lane: restoring divider, one quotient bit per pipeline stage
// quotient must fit in Q_W bits; no dependencies
module aoc_div_lane #(
    parameter int N_W = 24,
    parameter int D_W = 18,
    parameter int Q_W = 8
) (
    input  logic           clk,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic [Q_W-1:0] quo
);

    localparam int C_W = ((N_W > D_W) ? N_W : D_W) + Q_W;

    logic [N_W-1:0] rem_reg [Q_W-1];
    logic [D_W-1:0] den_reg [Q_W-1];
    logic [Q_W-1:0] quo_reg [Q_W];

    for (genvar k = 0; k < Q_W; k++)
    begin : g_step
        logic [N_W-1:0] rem_in;
        logic [D_W-1:0] den_in;
        logic [Q_W-1:0] quo_in;
        logic [C_W-1:0] trial;
        logic [C_W-1:0] diff;
        logic           fits;
        logic [N_W-1:0] rem_next;
        logic [Q_W-1:0] quo_next;

        if (k == 0)
        begin : g_first
            assign rem_in = num;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        always_comb
        begin
            trial    = {{(C_W-D_W){1'b0}}, den_in} << (Q_W - 1 - k);
            fits     = {{(C_W-N_W){1'b0}}, rem_in} >= trial;
            diff     = {{(C_W-N_W){1'b0}}, rem_in} - trial;
            rem_next = fits ? diff[N_W-1:0] : rem_in;
            quo_next = quo_in;
            quo_next[Q_W-1-k] = fits;
        end

        always_ff @(posedge clk)
        begin
            quo_reg[k] <= quo_next;
        end

        if (k < Q_W - 1)
        begin : g_keep
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[Q_W-1];

endmodule

/* rtl/aoc_checker.sv */
// aoc_checker: port-level checks for the alpha over compositor, bound to the top
// uses aoc_pkg for the pipeline latency
module aoc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [aoc_pkg::PIX_W-1:0] src_alpha,
    input logic [aoc_pkg::PIX_W-1:0] dst_red,
    input logic [aoc_pkg::PIX_W-1:0] dst_green,
    input logic [aoc_pkg::PIX_W-1:0] dst_blue,
    input logic [aoc_pkg::PIX_W-1:0] dst_alpha,
    input logic                      done,
    input logic [aoc_pkg::PIX_W-1:0] out_red,
    input logic [aoc_pkg::PIX_W-1:0] out_green,
    input logic [aoc_pkg::PIX_W-1:0] out_blue,
    input logic [aoc_pkg::PIX_W-1:0] out_alpha,
    input logic                      blended
);

    a_beat_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(aoc_pkg::PIPE_LAT) done)
        else $error("accepted beat not delivered after pipeline latency");

    a_no_extra_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##(aoc_pkg::PIPE_LAT) !done)
        else $error("result beat without an accepted input");

    a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !blended) |->
            (out_red == $past(dst_red, aoc_pkg::PIPE_LAT)) &&
            (out_green == $past(dst_green, aoc_pkg::PIPE_LAT)) &&
            (out_blue == $past(dst_blue, aoc_pkg::PIPE_LAT)) &&
            (out_alpha == $past(dst_alpha, aoc_pkg::PIPE_LAT)))
        else $error("pass-through pixel differs from destination");

    a_blend_needs_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (done && blended) |-> ($past(src_alpha, aoc_pkg::PIPE_LAT) != '0))
        else $error("blend reported for a transparent source");

endmodule

bind alpha_over_compositor_top aoc_checker u_aoc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .src_alpha(src_alpha),
    .dst_red(dst_red),
    .dst_green(dst_green),
    .dst_blue(dst_blue),
    .dst_alpha(dst_alpha),
    .done(done),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_alpha(out_alpha),
    .blended(blended)
);

/* tb/alpha_over_compositor_top_tb.sv */
// alpha_over_compositor_top_tb: self-checking bench for the source-over pixel blender
// a scoreboard class predicts each composited pixel from its own copy of the layer registers
// depends on aoc_pkg and alpha_over_compositor_top
module alpha_over_compositor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aoc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
    localparam longint unsigned Q_ONE = 64'd1 << FRAC_BITS_DEF;
    localparam longint unsigned OPACITY_FULL = 64'd65536;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] alpha;
    } rgba_t;

    typedef struct packed {
        rgba_t pix;
        logic  blended;
    } composite_t;

    class blend_scoreboard;
        logic [OPACITY_W-1:0] opacity;
        logic                 visible;
        composite_t           expected_q[$];
        int                   errors;

        function new();
            opacity = OPACITY_ONE;
            visible = 1'b1;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_LAYER_OPACITY: opacity = data;
                REG_LAYER_VISIBLE: visible = data[0];
                default: ;
            endcase
        endfunction

        function void note_pixel(rgba_t src, rgba_t dst);
            longint unsigned op, sa, da, dt, oa, den, c;
            composite_t r;
            op = (opacity > OPACITY_FULL) ? OPACITY_FULL : longint'(opacity);
            op = op * Q_ONE / OPACITY_FULL;
            sa = longint'(src.alpha) * op / BYTE_MAX;
            if (!visible || sa < ALPHA_EPSILON_DEF)
            begin
                r.pix     = dst;
                r.blended = 1'b0;
            end
            else
            begin
                da  = longint'(dst.alpha) * Q_ONE / BYTE_MAX;
                dt  = (da * (Q_ONE - sa)) >> FRAC_BITS_DEF;
                oa  = sa + dt;
                den = oa + ALPHA_EPSILON_DEF;
                for (int k = 0; k < 3; k++)
                begin
                    c = (longint'(src[31-8*k -: 8]) * sa + longint'(dst[31-8*k -: 8]) * dt) / den;
                    r.pix[31-8*k -: 8] = (c > BYTE_MAX) ? 8'd255 : c[7:0];
                end
                c = (oa * BYTE_MAX) >> FRAC_BITS_DEF;
                r.pix.alpha = (c > BYTE_MAX) ? 8'd255 : c[7:0];
                r.blended   = 1'b1;
            end
            expected_q.push_back(r);
        endfunction

        function void compare_field(string what, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
            end
        endfunction

        function void check_result(composite_t got);
            composite_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none got %h", $time, got);
                return;
            end
            want = expected_q.pop_front();
            compare_field("out_red", want.pix.red, got.pix.red);
            compare_field("out_green", want.pix.green, got.pix.green);
            compare_field("out_blue", want.pix.blue, got.pix.blue);
            compare_field("out_alpha", want.pix.alpha, got.pix.alpha);
            compare_field("blended", PIX_W'(want.blended), PIX_W'(got.blended));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [PIX_W-1:0]       src_red, src_green, src_blue, src_alpha;
    logic [PIX_W-1:0]       dst_red, dst_green, dst_blue, dst_alpha;
    logic                   done;
    logic [PIX_W-1:0]       out_red, out_green, out_blue, out_alpha;
    logic                   blended;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    blend_scoreboard sb;
    int sender_idle_pct;
    int cycles = 0;

    alpha_over_compositor_top u_top (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[alpha_over_compositor_top] ERROR");
            $finish;
        end
    end

    // beat monitors, sampled before this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_pixel('{src_red, src_green, src_blue, src_alpha},
                              '{dst_red, dst_green, dst_blue, dst_alpha});
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (done)
                sb.check_result('{'{out_red, out_green, out_blue, out_alpha}, blended});
        end
    end

    function automatic rgba_t px(int r, int g, int b, int a);
        px = '{r[7:0], g[7:0], b[7:0], a[7:0]};
    endfunction

    function automatic logic [PIX_W-1:0] rand_channel();
        case ($urandom_range(7))
            0:       rand_channel = 8'd0;
            1:       rand_channel = 8'd255;
            default: rand_channel = PIX_W'($urandom_range(255));
        endcase
    endfunction

    function automatic rgba_t rand_pixel();
        rgba_t p;
        p.red   = rand_channel();
        p.green = rand_channel();
        p.blue  = rand_channel();
        case ($urandom_range(7))
            0:       p.alpha = 8'd0;
            1:       p.alpha = 8'd255;
            2:       p.alpha = PIX_W'($urandom_range(1, 3));
            default: p.alpha = PIX_W'($urandom_range(255));
        endcase
        return p;
    endfunction

    task automatic send_pixel(input rgba_t src, input rgba_t dst);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        start     <= 1'b1;
        src_red   <= src.red;
        src_green <= src.green;
        src_blue  <= src.blue;
        src_alpha <= src.alpha;
        dst_red   <= dst.red;
        dst_green <= dst.green;
        dst_blue  <= dst.blue;
        dst_alpha <= dst.alpha;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic stop_stream();
        start <= 1'b0;
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // spare indexes carry junk that must not touch the layer registers
    task automatic program_layer(input logic [CFG_DATA_W-1:0] opacity, input logic visible);
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        write_cfg(REG_SPARE_A, CFG_DATA_W'($urandom_range(131071)));
        write_cfg(REG_LAYER_OPACITY, opacity);
        write_cfg(REG_LAYER_VISIBLE, {{(CFG_DATA_W-1){1'b0}}, visible});
        write_cfg(REG_SPARE_B, CFG_DATA_W'($urandom_range(131071)));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_block(input int count);
        logic [CFG_DATA_W-1:0] opacity;
        case ($urandom_range(5))
            0:       opacity = '0;
            1:       opacity = OPACITY_ONE;
            2:       opacity = 17'h1FFFF;
            3:       opacity = CFG_DATA_W'($urandom_range(131071));
            4:       opacity = CFG_DATA_W'($urandom_range(40, 400));
            default: opacity = CFG_DATA_W'($urandom_range(1, 65536));
        endcase
        program_layer(opacity, $urandom_range(7) != 0);
        repeat (count)
            send_pixel(rand_pixel(), rand_pixel());
        stop_stream();
    endtask

    initial
    begin
        sb              = new();
        sender_idle_pct = 26;
        rst_n           = 1'b0;
        start           = 1'b0;
        src_red         = '0;
        src_green       = '0;
        src_blue        = '0;
        src_alpha       = '0;
        dst_red         = '0;
        dst_green       = '0;
        dst_blue        = '0;
        dst_alpha       = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: opaque and visible
        send_pixel(px(0, 0, 0, 0), px(0, 0, 0, 0));
        send_pixel(px(255, 255, 255, 255), px(0, 0, 0, 0));
        send_pixel(px(255, 255, 255, 255), px(255, 255, 255, 255));
        send_pixel(px(0, 0, 0, 255), px(255, 255, 255, 255));
        send_pixel(px(255, 0, 128, 1), px(10, 200, 30, 255));
        send_pixel(px(12, 34, 56, 0), px(255, 128, 1, 254));
        send_pixel(px(200, 100, 50, 128), px(50, 100, 200, 0));
        send_pixel(px(170, 85, 15, 128), px(85, 170, 240, 128));
        stop_stream();

        // source alpha right at the faint threshold
        program_layer(17'd66, 1'b1);
        send_pixel(px(255, 255, 255, 255), px(1, 2, 3, 4));
        send_pixel(px(255, 255, 255, 254), px(1, 2, 3, 4));
        send_pixel(px(0, 255, 0, 255), px(255, 0, 255, 255));
        stop_stream();

        // opacity above one saturates
        program_layer(17'h1FFFF, 1'b1);
        send_pixel(px(255, 255, 255, 255), px(0, 0, 0, 0));
        send_pixel(px(100, 150, 200, 77), px(3, 4, 5, 200));
        send_pixel(px(9, 8, 7, 1), px(90, 80, 70, 60));
        stop_stream();
        program_layer(17'h10001, 1'b1);
        send_pixel(px(60, 70, 80, 90), px(200, 210, 220, 230));
        stop_stream();

        program_layer(17'd0, 1'b1);
        send_pixel(px(255, 255, 255, 255), px(7, 7, 7, 7));
        send_pixel(px(1, 2, 3, 128), px(250, 251, 252, 253));
        stop_stream();

        // hidden layer passes destination
        program_layer(OPACITY_ONE, 1'b0);
        send_pixel(px(255, 255, 255, 255), px(0, 0, 0, 0));
        send_pixel(px(1, 2, 3, 4), px(255, 255, 255, 255));
        stop_stream();

        program_layer(17'd32768, 1'b1);
        send_pixel(px(240, 16, 99, 200), px(15, 255, 0, 100));
        send_pixel(px(255, 255, 255, 255), px(0, 0, 0, 255));
        stop_stream();
        program_layer(17'hFFFF, 1'b1);
        send_pixel(px(128, 64, 32, 255), px(32, 64, 128, 255));
        stop_stream();

        sender_idle_pct = 26;
        repeat (4) random_block(54);
        sender_idle_pct = 64;
        repeat (4) random_block(54);
        sender_idle_pct = 0;
        repeat (4) random_block(54);

        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
        if (sb.errors == 0)
            $display("[alpha_over_compositor_top] OK");
        else
            $display("[alpha_over_compositor_top] ERROR");
        $finish;
    end

endmodule
